>>> hw/rtl/mandelbrot_pixel_shader_macros.svh
// Assertion macros shared by the shader RTL.
// No dependencies.
`ifndef MANDELBROT_PIXEL_SHADER_MACROS_SVH
`define MANDELBROT_PIXEL_SHADER_MACROS_SVH

// assert that antecedent implies consequent on the next cycle
`define MPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// assert that antecedent implies consequent in the same cycle
`define MPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/mps_pkg.sv
// Package for the Mandelbrot pixel shader: types, constants, state codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mps_pkg;
    localparam int FRAC_BITS  = 28;
    localparam int DIM_BITS   = 12;
    localparam int COUNT_BITS = 16;
    localparam int COORD_W    = FRAC_BITS + 4;
    localparam int CFG_W      = 32;
    localparam int IDX_W      = 3;

    localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_ZOOM   = 3'd2;
    localparam logic [IDX_W-1:0] REG_CRE    = 3'd3;
    localparam logic [IDX_W-1:0] REG_CIM    = 3'd4;
    localparam logic [IDX_W-1:0] REG_LIMIT  = 3'd5;

    typedef struct packed {
        logic [11:0] pixel_col;
        logic [11:0] pixel_row;
    } pixel_req_t;

    typedef struct packed {
        logic [15:0] escape_count;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } pixel_rsp_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_MAPMUL, OP_DIVSTEP, OP_MAPADD, OP_SQ, OP_UPD,
        OP_PALSEL, OP_PALDIV, OP_DONE
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MAPMUL, ST_DIV, ST_MAPADD, ST_SQ, ST_UPD, ST_PALSEL,
        ST_PALDIV, ST_OUT
    } state_t;

    typedef struct packed {
        op_t op;
    } mps_cmd_t;

    typedef struct packed {
        logic div_last;
        logic iter_stop;
    } mps_sts_t;
endpackage
`default_nettype wire

>>> hw/rtl/mps_ctrl.sv
// Controller state machine of the shader.
// Depends on mps_pkg and the macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "mandelbrot_pixel_shader_macros.svh"
module mps_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_fire,
    input  wire logic            out_busy,
    input  wire mps_pkg::mps_sts_t sts,
    output mps_pkg::mps_cmd_t     cmd,
    output logic                  in_ready
);
    import mps_pkg::*;
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_MAPMUL;
                end
            end
            ST_MAPMUL:
            begin
                cmd.op     = OP_MAPMUL;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op = OP_DIVSTEP;
                if (sts.div_last)
                    state_next = ST_MAPADD;
            end
            ST_MAPADD:
            begin
                cmd.op     = OP_MAPADD;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.op     = OP_SQ;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.op     = OP_UPD;
                state_next = sts.iter_stop ? ST_PALSEL : ST_SQ;
            end
            ST_PALSEL:
            begin
                cmd.op     = OP_PALSEL;
                state_next = ST_PALDIV;
            end
            ST_PALDIV:
            begin
                cmd.op = OP_PALDIV;
                if (sts.div_last)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_busy)
                begin
                    cmd.op     = OP_DONE;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `MPS_ASSERT_NEXT(a_load_leaves_idle, clk, rst_n, in_fire, state_reg == ST_MAPMUL)
    `MPS_ASSERT_SAME(a_ready_idle_only, clk, rst_n, in_ready, state_reg == ST_IDLE)
    `MPS_ASSERT_SAME(a_done_free, clk, rst_n, cmd.op == OP_DONE, !out_busy)
endmodule
`default_nettype wire

>>> hw/rtl/mps_datapath.sv
// Datapath of the shader: mapping, x/y and palette dividers, iteration, palette.
// Depends on mps_pkg and the macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "mandelbrot_pixel_shader_macros.svh"
module mps_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mps_pkg::mps_cmd_t   cmd,
    input  wire mps_pkg::pixel_req_t req,
    input  wire logic [12:0]         cfg_w,
    input  wire logic [12:0]         cfg_h,
    input  wire logic [30:0]         cfg_zoom,
    input  wire logic signed [31:0]  cfg_cre,
    input  wire logic signed [31:0]  cfg_cim,
    input  wire logic [15:0]         cfg_limit,
    output mps_pkg::mps_sts_t        sts,
    output mps_pkg::pixel_rsp_t      rsp
);
    import mps_pkg::*;
    localparam int CW = COORD_W;
    localparam int DIVW = 48;  // span*pos < 2^34*2^12
    localparam int MW = DIVW + 2;  // centre - span/2 + quotient, signed
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW+2:0] FOUR = (CW+3)'(4) <<< FRAC_BITS;

    // span = 7*zoom, 34 bits
    logic [33:0]         span;
    logic [11:0]         col_reg, row_reg;
    logic [DIVW-1:0]     numx_reg, numy_reg, remx_reg, remy_reg;
    logic [12:0]         denx, deny;
    logic [5:0]          dcnt_reg, dcnt_next;
    logic signed [CW-1:0] cr_reg, ci_reg, zr_reg, zi_reg;
    logic signed [CW-1:0] zr2_reg, zi2_reg, zri_reg;
    logic [15:0]         n_reg, lim_reg;
    logic                stop_reg;
    logic [7:0]          r_reg, g_reg, b_reg;
    // palette division: value num/den, 26-bit numerator
    logic [25:0]         pnum_reg, prem_reg;
    logic [19:0]         pden_reg;
    logic [1:0]          pseg_reg;
    logic [25:0]         pq, prem_step;
    logic [DIVW:0]       trx, try_;
    logic [26:0]         trp;
    logic signed [CW+2:0] mag2, nr_s, ni_s;

    assign span = 34'(cfg_zoom) * 34'd7;
    assign denx = (cfg_w == 13'd0) ? 13'd1 : cfg_w;
    assign deny = (cfg_h == 13'd0) ? 13'd1 : cfg_h;

    function automatic logic signed [CW-1:0] sat_w(input logic signed [CW+2:0] v);
        if (v > (CW+3)'(CMAX))
            return CMAX;
        else if (v < (CW+3)'(CMIN))
            return CMIN;
        else
            return v[CW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] sat_map(input logic signed [MW-1:0] v);
        if (v > MW'(CMAX))
            return CMAX;
        else if (v < MW'(CMIN))
            return CMIN;
        else
            return v[CW-1:0];
    endfunction

    // Saturating product truncated toward zero.
    function automatic logic signed [CW-1:0] fmul(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        logic [CW-1:0]   ua, ub;
        logic [2*CW-1:0] p;
        logic [2*CW-1:0] m;
        logic            neg;
        neg = a[CW-1] ^ b[CW-1];
        ua  = a[CW-1] ? -a : a;
        ub  = b[CW-1] ? -b : b;
        p   = ua * ub;
        m   = p >> FRAC_BITS;
        if (neg)
        begin
            if (m >= (2*CW)'({1'b1, {(CW-1){1'b0}}}))
                return CMIN;
            return -(m[CW-1:0]);
        end
        if (m > (2*CW)'(CMAX))
            return CMAX;
        return m[CW-1:0];
    endfunction

    assign trx  = {remx_reg[DIVW-2:0], numx_reg[DIVW-1]} - {1'b0, 35'd0, denx};
    assign try_ = {remy_reg[DIVW-2:0], numy_reg[DIVW-1]} - {1'b0, 35'd0, deny};
    assign trp  = {prem_reg[24:0], pnum_reg[25]} - {7'd0, pden_reg};
    assign pq        = {pnum_reg[24:0], ~trp[26]};
    assign prem_step = trp[26] ? {prem_reg[24:0], pnum_reg[25]} : trp[25:0];

    assign mag2 = (CW+3)'(zr2_reg) + (CW+3)'(zi2_reg);
    assign nr_s = (CW+3)'(zr2_reg) - (CW+3)'(zi2_reg) + (CW+3)'(cr_reg);
    assign ni_s = ((CW+3)'(zri_reg) <<< 1) + (CW+3)'(ci_reg);

    always_comb
    begin
        dcnt_next = dcnt_reg + 6'd1;
        sts.div_last  = (cmd.op == OP_DIVSTEP) ? (dcnt_reg == 6'(DIVW-1))
                                               : (dcnt_reg == 6'd25);
        // limit reached or escaped: this update is the last one
        sts.iter_stop = stop_reg || (mag2 > FOUR);
    end

    logic [19:0] n4, n20, l15;
    assign n4  = {2'b00, n_reg, 2'b00};
    assign n20 = 20'(n_reg) * 20'd20;
    assign l15 = 20'(lim_reg) * 20'd15;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (cmd.op == OP_DIVSTEP || cmd.op == OP_PALDIV)
            dcnt_reg <= sts.div_last ? 6'd0 : dcnt_next;
        else
            dcnt_reg <= '0;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                col_reg <= req.pixel_col;
                row_reg <= req.pixel_row;
                lim_reg <= cfg_limit;
            end
            OP_MAPMUL:
            begin
                numx_reg <= DIVW'(span) * DIVW'(col_reg);
                numy_reg <= DIVW'(span) * DIVW'(row_reg);
                remx_reg <= '0;
                remy_reg <= '0;
            end
            OP_DIVSTEP:
            begin
                numx_reg <= {numx_reg[DIVW-2:0], ~trx[DIVW]};
                remx_reg <= trx[DIVW] ? {remx_reg[DIVW-2:0], numx_reg[DIVW-1]}
                                      : trx[DIVW-1:0];
                numy_reg <= {numy_reg[DIVW-2:0], ~try_[DIVW]};
                remy_reg <= try_[DIVW] ? {remy_reg[DIVW-2:0], numy_reg[DIVW-1]}
                                       : try_[DIVW-1:0];
            end
            OP_MAPADD:
            begin
                // quotient can come close to 2^46, so the sum is formed wide before saturation
                cr_reg <= sat_map(MW'(cfg_cre) - MW'(span >> 1) + MW'(numx_reg));
                ci_reg <= sat_map(MW'(cfg_cim) - MW'(span >> 1) + MW'(numy_reg));
                zr_reg <= '0;
                zi_reg <= '0;
                n_reg  <= '0;
                stop_reg <= (cfg_limit == 16'd0);
            end
            OP_SQ:
            begin
                zr2_reg <= fmul(zr_reg, zr_reg);
                zi2_reg <= fmul(zi_reg, zi_reg);
                zri_reg <= fmul(zr_reg, zi_reg);
                stop_reg <= (n_reg >= lim_reg);
            end
            OP_UPD:
            begin
                if (!stop_reg && mag2 <= FOUR)
                begin
                    zr_reg <= sat_w(nr_s);
                    zi_reg <= sat_w(ni_s);
                    n_reg  <= n_reg + 16'd1;
                end
                else
                    stop_reg <= 1'b1;
            end
            OP_PALSEL:
            begin
                prem_reg <= '0;
                r_reg <= '0;
                g_reg <= '0;
                b_reg <= '0;
                if (lim_reg == 16'd0)
                begin
                    pseg_reg <= 2'd3;
                    pnum_reg <= '0;
                    pden_reg <= 20'd1;
                end
                else if (n4 <= 20'(lim_reg))
                begin
                    pseg_reg <= 2'd0;
                    pnum_reg <= 26'(n4) * 26'd255;
                    pden_reg <= 20'(lim_reg);
                end
                else if (n4 <= 20'(lim_reg) * 20'd3)
                begin
                    pseg_reg <= 2'd1;
                    pnum_reg <= 26'(n4 - 20'(lim_reg)) * 26'd255;
                    pden_reg <= 20'(lim_reg) << 1;
                end
                else if (20'(n_reg) * 20'd10 < 20'(lim_reg) * 20'd9)
                begin
                    pseg_reg <= 2'd2;
                    pnum_reg <= 26'(n20 - l15) * 26'd255;
                    pden_reg <= 20'(lim_reg) * 20'd3;
                end
                else
                begin
                    pseg_reg <= 2'd3;
                    pnum_reg <= '0;
                    pden_reg <= 20'd1;
                end
            end
            OP_PALDIV:
            begin
                pnum_reg <= pq;
                prem_reg <= prem_step;
                if (sts.div_last)
                begin
                    // q = floor(255*t); rising channel is q, falling 255-q, one less if
                    // rem != 0 (exact: floor(255 - 255t) = 255 - ceil(255t))
                    case (pseg_reg)
                        2'd0:
                        begin
                            g_reg <= pq[7:0];
                            r_reg <= 8'd255 - pq[7:0]
                                     - ((prem_step != 26'd0) ? 8'd1 : 8'd0);
                        end
                        2'd1:
                        begin
                            b_reg <= pq[7:0];
                            g_reg <= 8'd255 - pq[7:0]
                                     - ((prem_step != 26'd0) ? 8'd1 : 8'd0);
                        end
                        2'd2:
                        begin
                            r_reg <= pq[7:0];
                            b_reg <= 8'd255;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign rsp.escape_count = n_reg;
    assign rsp.red          = r_reg;
    assign rsp.green        = g_reg;
    assign rsp.blue         = b_reg;

    `MPS_ASSERT_NEXT(a_count_step, clk, rst_n, cmd.op == OP_UPD && !stop_reg && mag2 <= FOUR, n_reg == $past(n_reg) + 16'd1)
    `MPS_ASSERT_SAME(a_count_limit, clk, rst_n, cmd.op == OP_PALSEL, n_reg <= lim_reg)
    `MPS_ASSERT_NEXT(a_stop_holds, clk, rst_n, cmd.op == OP_UPD && stop_reg, stop_reg)
endmodule
`default_nettype wire

>>> hw/rtl/mandelbrot_pixel_shader.sv
// Mandelbrot escape-time pixel shader, top level: config registers, output stage.
// Depends on mps_pkg, mps_ctrl, mps_datapath.
// Per pixel: map multiply, restoring divide steps, map add, then a square and an update
//   state per iteration, palette select, palette divide steps and the output load.
// One pixel in flight; the next request is taken in idle, entered as the result loads.
// Reset (rst_n, async low) restores the registers to 640, 480, 1.0, 0, 0, 256.
`timescale 1ns / 1ps
`default_nettype none
module mandelbrot_pixel_shader (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire mps_pkg::pixel_req_t in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output mps_pkg::pixel_rsp_t      out_data,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);
    import mps_pkg::*;

    logic [12:0]        w_reg, h_reg;
    logic [30:0]        zoom_reg;
    logic signed [31:0] cre_reg, cim_reg;
    logic [15:0]        lim_reg;
    logic               ovalid_reg;
    pixel_rsp_t         odata_reg;
    mps_cmd_t           cmd;
    mps_sts_t           sts;
    pixel_rsp_t         rsp;
    logic               in_fire;
    logic               out_busy;

    assign in_fire  = in_valid && in_ready;
    // output register still holds a result nobody took
    assign out_busy = ovalid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg    <= 13'd640;
            h_reg    <= 13'd480;
            zoom_reg <= 31'(1) << FRAC_BITS;
            cre_reg  <= '0;
            cim_reg  <= '0;
            lim_reg  <= 16'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  w_reg    <= cfg_data[12:0];
                REG_HEIGHT: h_reg    <= cfg_data[12:0];
                REG_ZOOM:   zoom_reg <= cfg_data[30:0];
                REG_CRE:    cre_reg  <= cfg_data;
                REG_CIM:    cim_reg  <= cfg_data;
                REG_LIMIT:  lim_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.op == OP_DONE)
            ovalid_reg <= 1'b1;
        else if (out_ready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_DONE)
            odata_reg <= rsp;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    mps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_busy (out_busy),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    mps_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (in_data),
        .cfg_w     (w_reg),
        .cfg_h     (h_reg),
        .cfg_zoom  (zoom_reg),
        .cfg_cre   (cre_reg),
        .cfg_cim   (cim_reg),
        .cfg_limit (lim_reg),
        .sts       (sts),
        .rsp       (rsp)
    );
endmodule
`default_nettype wire
